/* rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg: lighting button controller shared definitions
// Item types, command and property codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lbc_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic       button_one_level;
    logic       button_two_level;
    logic [7:0] detect_code;
    logic [7:0] property_code;
    logic       from_sensor_node;
  } lbc_in_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] property_out;
    logic [7:0] value_out;
    logic       last;
  } lbc_out_t;

  // results of one item, packed in order; n gives how many are valid
  typedef struct packed {
    logic [1:0]         n;
    lbc_out_t [2:0]     res;
  } lbc_push_t;

  localparam int LBC_QDEPTH = 4;
  localparam int LBC_CFG_DW = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_DETECT = 2'd1;
  localparam logic [1:0] KIND_PROP   = 2'd2;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_POWER  = 2'd2;
  localparam logic [1:0] CMD_MODE   = 2'd3;

  localparam logic [7:0] PROP_NONE   = 8'h00;
  localparam logic [7:0] PROP_SEARCH = 8'hD6;
  localparam logic [7:0] PROP_POWER  = 8'h80;
  localparam logic [7:0] PROP_MODE   = 8'hB6;

  localparam logic [7:0] VAL_NONE    = 8'h00;
  localparam logic [7:0] VAL_ON      = 8'h30;
  localparam logic [7:0] VAL_OFF     = 8'h31;
  localparam logic [7:0] VAL_AUTO    = 8'h41;
  localparam logic [7:0] VAL_NORMAL  = 8'h42;
  localparam logic [7:0] VAL_NIGHT   = 8'h43;
  localparam logic [7:0] VAL_COLOR   = 8'h45;

  localparam logic [7:0] DET_PRESENT = 8'h41;
  localparam logic [7:0] DET_ABSENT  = 8'h42;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_IDLE   = 2'd1;
  localparam logic [1:0] PH_SEARCH = 2'd2;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_NIGHT  = 2'd2;
  localparam logic [1:0] MODE_COLOR  = 2'd3;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_START    = 2'd1;
  localparam logic [1:0] CFG_FIRST    = 2'd2;
  localparam logic [1:0] CFG_RETRY    = 2'd3;

  localparam logic [4:0]  RST_DEBOUNCE = 5'd10;
  localparam logic [15:0] RST_START    = 16'd100;
  localparam logic [15:0] RST_FIRST    = 16'd100;
  localparam logic [15:0] RST_RETRY    = 16'd500;

endpackage

/* rtl/lighting_button_controller_unit.sv */
// ----------------------------------------------------------------------------
// lighting_button_controller_unit: lighting button controller top level
// An item's results join the result queue at its transfer, after older ones.
// Throughput: one item per cycle unless in_stall; results leave one per cycle
// unless out_stall; input is held off while under three entries are free.
// Reset (synchronous, rst_n low) restores registers and state to defaults
// and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module lighting_button_controller_unit #(
  parameter int QDEPTH = lbc_pkg::LBC_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbc_pkg::lbc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lbc_pkg::lbc_out_t  out_data
);
  import lbc_pkg::*;

  logic      step;
  lbc_push_t push;

  assign step = in_valid & ~in_stall;

  lbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (in_data),
    .push      (push)
  );

  lbc_out_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/lbc_core.sv */
// ----------------------------------------------------------------------------
// lbc_core: controller state and per-item step
// Holds the registers, sequencer, debouncers and light state; turns one
// accepted item into up to three ordered results in the cycle it is accepted.
// ----------------------------------------------------------------------------
module lbc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               step,
  input  lbc_pkg::lbc_in_t   item,
  output lbc_pkg::lbc_push_t push
);
  import lbc_pkg::*;

  logic [4:0]  limit_r;
  logic [15:0] first_r, retry_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] cd_r, cd_nxt;
  logic        cd_en_r, cd_en_nxt;
  logic        held1_r, held1_nxt, held2_r, held2_nxt;
  logic [4:0]  mis1_r, mis1_nxt, mis2_r, mis2_nxt;
  logic        light_r, light_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic [15:0] cd_dec;
  logic [6:0]  db1, db2;
  logic        seq_hit, pwr_hit, mode_hit;
  lbc_out_t    seq_res, pwr_res, mode_res;
  lbc_push_t   push_c;

  // returns {release, held, count}
  function automatic logic [6:0] debounce(input logic lvl, input logic held,
                                          input logic [4:0] cnt,
                                          input logic [4:0] lim);
    logic [5:0] nx;
    nx = {1'b0, cnt} + 6'd1;
    if (lvl == held) begin
      return {1'b0, held, cnt};
    end else if (nx > {1'b0, lim}) begin
      return {~lvl, lvl, 5'd0};
    end else begin
      return {1'b0, held, nx[4:0]};
    end
  endfunction

  assign cd_dec = (cd_r != 16'd0) ? (cd_r - 16'd1) : 16'd0;
  assign db1 = debounce(item.button_one_level, held1_r, mis1_r, limit_r);
  assign db2 = debounce(item.button_two_level, held2_r, mis2_r, limit_r);

  always_comb begin
    phase_nxt = phase_r;
    cd_nxt    = cd_r;
    cd_en_nxt = cd_en_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    mis1_nxt  = mis1_r;
    mis2_nxt  = mis2_r;
    light_nxt = light_r;
    mode_nxt  = mode_r;
    seq_hit   = 1'b0;
    pwr_hit   = 1'b0;
    mode_hit  = 1'b0;
    seq_res   = '{CMD_START, PROP_NONE, VAL_NONE, 1'b0};
    pwr_res   = '{CMD_POWER, PROP_POWER, VAL_ON, 1'b0};
    mode_res  = '{CMD_MODE, PROP_MODE, VAL_AUTO, 1'b1};
    if (step) begin
      case (item.kind)
        KIND_TICK: begin
          if (cd_en_r) begin
            cd_nxt = cd_dec;
            if (cd_dec == 16'd0) begin
              if (phase_r == PH_START) begin
                seq_hit   = 1'b1;
                phase_nxt = PH_SEARCH;
                cd_nxt    = first_r;
              end else if (phase_r == PH_SEARCH) begin
                seq_hit   = 1'b1;
                seq_res   = '{CMD_SEARCH, PROP_SEARCH, VAL_NONE, 1'b0};
                cd_nxt    = retry_r;
              end
            end
          end
          held1_nxt = db1[5];
          mis1_nxt  = db1[4:0];
          held2_nxt = db2[5];
          mis2_nxt  = db2[4:0];
          if (db1[6]) begin
            pwr_hit   = 1'b1;
            light_nxt = ~light_r;
            pwr_res.value_out = light_r ? VAL_OFF : VAL_ON;
          end
          if (db2[6]) begin
            mode_hit = 1'b1;
            case (mode_r)
              MODE_AUTO: begin
                mode_nxt = MODE_NORMAL;
                mode_res.value_out = VAL_NORMAL;
              end
              MODE_NORMAL: begin
                mode_nxt = MODE_NIGHT;
                mode_res.value_out = VAL_NIGHT;
              end
              MODE_NIGHT: begin
                mode_nxt = MODE_COLOR;
                mode_res.value_out = VAL_COLOR;
              end
              default: begin
                mode_nxt = MODE_AUTO;
                mode_res.value_out = VAL_AUTO;
              end
            endcase
          end
        end
        KIND_DETECT: begin
          if (phase_r == PH_IDLE) begin
            if (!light_r && item.detect_code == DET_PRESENT) begin
              pwr_hit   = 1'b1;
              light_nxt = 1'b1;
            end else if (light_r && item.detect_code == DET_ABSENT) begin
              pwr_hit   = 1'b1;
              light_nxt = 1'b0;
              pwr_res.value_out = VAL_OFF;
            end
          end
        end
        KIND_PROP: begin
          if (item.property_code == PROP_SEARCH && phase_r == PH_SEARCH &&
              item.from_sensor_node) begin
            phase_nxt = PH_IDLE;
            cd_en_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (cfg_we && cfg_index == CFG_START && phase_r == PH_START) begin
      cd_nxt = cfg_data;
    end
    seq_res.last = ~(pwr_hit | mode_hit);
    pwr_res.last = ~mode_hit;
  end

  always_comb begin
    push_c = '0;
    if (seq_hit) begin
      push_c.res[push_c.n] = seq_res;
      push_c.n = push_c.n + 2'd1;
    end
    if (pwr_hit) begin
      push_c.res[push_c.n] = pwr_res;
      push_c.n = push_c.n + 2'd1;
    end
    if (mode_hit) begin
      push_c.res[push_c.n] = mode_res;
      push_c.n = push_c.n + 2'd1;
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RST_DEBOUNCE;
      first_r <= RST_FIRST;
      retry_r <= RST_RETRY;
      phase_r <= PH_START;
      cd_r    <= RST_START;
      cd_en_r <= 1'b1;
      held1_r <= 1'b0;
      held2_r <= 1'b0;
      mis1_r  <= 5'd0;
      mis2_r  <= 5'd0;
      light_r <= 1'b0;
      mode_r  <= MODE_AUTO;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEBOUNCE: limit_r <= cfg_data[4:0];
          CFG_FIRST:    first_r <= cfg_data;
          CFG_RETRY:    retry_r <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      cd_en_r <= cd_en_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
      mis1_r  <= mis1_nxt;
      mis2_r  <= mis2_nxt;
      light_r <= light_nxt;
      mode_r  <= mode_nxt;
    end
  end

  a_idle_no_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !cd_en_r)
    else $error("countdown still running in idle");

  a_no_result_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |-> (push.n == 2'd0))
    else $error("result produced without an item transfer");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) || (phase_r == PH_IDLE) || (phase_r == PH_SEARCH))
    else $error("sequencer phase out of range");

endmodule

/* rtl/lbc_out_queue.sv */
// ----------------------------------------------------------------------------
// lbc_out_queue: result queue
// Takes up to three ordered results per cycle and hands them out one per
// transfer; holds off input while fewer than three entries are free.
// ----------------------------------------------------------------------------
module lbc_out_queue #(
  parameter int DEPTH = lbc_pkg::LBC_QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbc_pkg::lbc_push_t  push,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lbc_pkg::lbc_out_t   out_data
);
  import lbc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lbc_out_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [1:0] k);
    logic [AW+1:0] s;
    s = {2'b00, p} + (AW+2)'(k);
    if (s >= (AW+2)'(DEPTH)) begin
      s = s - (AW+2)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  assign in_stall  = (cnt_r > CW'(DEPTH - 3));
  assign cnt_nxt   = cnt_r + CW'(push.n) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.n) begin
        mem_r[wrap(wr_ptr_r, 2'(i))] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wrap(wr_ptr_r, push.n);
      if (pop) begin
        rd_ptr_r <= wrap(rd_ptr_r, 2'd1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (cnt_r <= CW'(DEPTH - 3)))
    else $error("results pushed into a full queue");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> push.res[push.n - 2'd1].last)
    else $error("final result of an item lacks last");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.n == 2'd0) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("queue count did not drop on transfer");

endmodule
